// ===== sv/sorted_priority_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// clocked property wrappers shared by the queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int KEY_W   = 32;
    localparam int LEVEL_W = 7;
    localparam int WEIGHT_W = 24;
    localparam int WORTH_W = 24;
    localparam int TAG_W   = 16;
    localparam int OCC_W   = 7;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 112;
    localparam int OUT_USER_W = 2;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [LEVEL_W-1:0]  level;
        logic [WEIGHT_W-1:0] weight;
        logic [WORTH_W-1:0]  worth;
        logic [TAG_W-1:0]    tag;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted list: takes the new entry, its upper or lower
// neighbor, or holds
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_head,
    input  logic              i_occ,
    input  spq_pkg::t_entry   i_new,
    input  spq_pkg::t_entry   i_prev,
    input  logic              i_prev_go,
    input  spq_pkg::t_entry   i_next,
    output logic              o_go,
    output spq_pkg::t_entry   o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs at or above this slot
    assign o_go = !i_occ ||
                  (i_head ? (r_entry.key < i_new.key) : (r_entry.key <= i_new.key));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_go) begin
            n_entry = i_prev_go ? i_prev : i_new;
        end else if (i_ctl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// sorted list priority queue built as a row of shifting cells
// ----------------------------------------------------------------------------
// slave stream: one beat per operation; tuser is the action (insert or
// remove), tdata carries the entry to insert and is ignored on a remove.
// master stream: one beat per operation; tuser is the status (ok, empty,
// full), tdata carries the removed entry (zero otherwise) and occupancy.
// every cell compares its key against the incoming key in parallel and
// either loads the new entry, its upper neighbor, its lower neighbor or
// holds, so the queue accepts one beat per cycle unless the master
// side stalls; the registered result shows in the cycle after the beat.
// the result register frees as the master side takes it, so a new input
// beat is taken while the held result is being accepted.
// when the receiver stalls, the result is held and the slave side
// stalls with it; no operation is lost or repeated.
// reset empties the queue (occupancy zero) and drops any held result;
// no clearing pass is needed, cell contents beyond the count are unused.
// an insert into a full queue is dropped with status full.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_macros.svh"

module sorted_priority_queue_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // level, weight, worth, bound_key, path_tag, pad
    input  logic [spq_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // action
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // out_level, out_weight, out_worth, out_bound, out_path_tag, occupancy, pad
    output logic [spq_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // status
    output logic [spq_pkg::OUT_USER_W-1:0]   o_m_tuser
);
    import spq_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;
    t_status               r_out_status;
    t_status               n_out_status;

    logic                  accept;
    logic                  is_remove;
    logic                  ins_ok;
    logic                  rem_ok;
    t_cell_ctl             ctl;
    t_entry                new_entry;
    t_entry                cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_go;
    logic [QUEUE_DEPTH-1:0] cell_occ;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_remove  = (t_action'(i_s_tuser) == ACT_REMOVE);
    assign ins_ok     = accept && !is_remove && (r_count != CNT_W'(QUEUE_DEPTH));
    assign rem_ok     = accept && is_remove && (r_count != '0);

    assign ctl.ins = ins_ok;
    assign ctl.rem = rem_ok;

    assign new_entry.level  = i_s_tdata[6:0];
    assign new_entry.weight = i_s_tdata[30:7];
    assign new_entry.worth  = i_s_tdata[54:31];
    assign new_entry.key    = i_s_tdata[86:55];
    assign new_entry.tag    = i_s_tdata[102:87];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry prev_entry;
        t_entry next_entry;
        logic   prev_go;

        assign cell_occ[g] = r_count > CNT_W'(g);

        if (g == 0) begin : g_first
            assign prev_entry = '0;
            assign prev_go    = 1'b0;
        end else begin : g_mid
            assign prev_entry = cell_entry[g-1];
            assign prev_go    = cell_go[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_inner
            assign next_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_head    (1'(g == 0)),
            .i_occ     (cell_occ[g]),
            .i_new     (new_entry),
            .i_prev    (prev_entry),
            .i_prev_go (prev_go),
            .i_next    (next_entry),
            .o_go      (cell_go[g]),
            .o_entry   (cell_entry[g])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        if (ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (rem_ok) begin
            n_count = r_count - CNT_W'(1);
        end
        if (accept) begin
            n_out_valid  = 1'b1;
            n_out_status = ST_OK;
            n_out_data   = '0;
            if (rem_ok) begin
                n_out_data[6:0]    = cell_entry[0].level;
                n_out_data[30:7]   = cell_entry[0].weight;
                n_out_data[54:31]  = cell_entry[0].worth;
                n_out_data[86:55]  = cell_entry[0].key;
                n_out_data[102:87] = cell_entry[0].tag;
            end else if (is_remove) begin
                n_out_status = ST_EMPTY;
            end else if (!ins_ok) begin
                n_out_status = ST_FULL;
            end
            n_out_data[109:103] = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "count above depth")

    `SPQ_ASSERT_NEXT(a_insert_grows, ins_ok, r_count == $past(r_count) + CNT_W'(1), "insert lost")

    `SPQ_ASSERT_NEXT(a_remove_shrinks, rem_ok, r_count == $past(r_count) - CNT_W'(1), "remove lost")

    `SPQ_ASSERT_NEXT(a_empty_status, accept && is_remove && (r_count == '0), o_m_tuser == ST_EMPTY, "empty not flagged")

    `SPQ_ASSERT_NOW(a_head_sorted, r_count >= CNT_W'(2), cell_entry[0].key >= cell_entry[1].key, "head out of order")

endmodule
